// ----- rtl/dpc_pkg.sv -----
package dpc_pkg;

    localparam int VALUE_BITS = 13;
    localparam int LIST_DEPTH = 128;
    localparam int COUNT_BITS = $clog2(LIST_DEPTH + 1);
    localparam int ADDR_BITS  = $clog2(LIST_DEPTH);
    localparam int SQ_BITS    = VALUE_BITS + 1;
    localparam int BIT_BITS   = $clog2(VALUE_BITS);

    localparam logic [VALUE_BITS-1:0] FIRST_DIVISOR = VALUE_BITS'(2);
    localparam logic [SQ_BITS-1:0]    FIRST_SQUARE  = SQ_BITS'(4);
    localparam logic [BIT_BITS-1:0]   BIT_TOP       = BIT_BITS'(VALUE_BITS - 1);

    typedef enum logic [2:0] {
        V_NOT_PRIME = 3'd0,
        V_KNOWN     = 3'd1,
        V_NEW       = 3'd2,
        V_FULL      = 3'd3,
        V_END       = 3'd4
    } t_verdict;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_WAIT,
        S_SEARCH,
        S_SEARCH_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [VALUE_BITS-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic done;
        logic zero;
    } t_mod_rsp;

endpackage

// ----- rtl/dpc_in_if.sv -----
interface dpc_in_if import dpc_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS:0]   value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ----- rtl/dpc_out_if.sv -----
interface dpc_out_if import dpc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [2:0]            verdict;
    logic [VALUE_BITS-1:0] echo_value;
    logic [COUNT_BITS-1:0] prime_count;

    modport source (output valid, output verdict, output echo_value, output prime_count,
                    input ready);
    modport sink   (input valid, input verdict, input echo_value, input prime_count,
                    output ready);
endinterface

// ----- rtl/dpc_ram.sv -----
module dpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/dpc_mod_unit.sv -----
module dpc_mod_unit import dpc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mod_req i_req,
    output t_mod_rsp o_rsp
);

    logic                  r_busy;
    logic                  r_done;
    logic [BIT_BITS-1:0]   r_bit;
    logic [VALUE_BITS-1:0] r_rem;
    logic [VALUE_BITS-1:0] r_dividend;
    logic [VALUE_BITS-1:0] r_divisor;

    logic [VALUE_BITS:0]   w_trial;
    logic [VALUE_BITS:0]   w_diff;
    logic                  w_ge;
    logic [VALUE_BITS-1:0] n_rem;

    // one restoring step per cycle, msb first
    always_comb begin
        w_trial = {r_rem, r_dividend[r_bit]};
        w_diff  = w_trial - {1'b0, r_divisor};
        w_ge    = w_trial >= {1'b0, r_divisor};
        n_rem   = w_ge ? w_diff[VALUE_BITS-1:0] : w_trial[VALUE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bit  <= BIT_TOP;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_bit  <= BIT_TOP;
            end else if (r_busy) begin
                if (r_bit == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_bit <= r_bit - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem      <= '0;
            r_dividend <= i_req.dividend;
            r_divisor  <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.zero = (r_rem == '0);

endmodule

// ----- rtl/distinct_prime_collector.sv -----
// flow: a negative value, zero or one goes straight to the result; a larger value is
// tried against each divisor up to sqrt(value) on the single remainder unit, and a prime
// is then searched for among the stored entries over the single ram port
// throughput: one item at a time, next transfer taken once the result is registered
// reset: synchronous active low, empties the prime list and drops any pending result
module distinct_prime_collector import dpc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    dpc_in_if.sink   i_in,
    dpc_out_if.source o_out
);

    t_state                r_state, n_state;
    logic [VALUE_BITS-1:0] r_value, n_value;
    logic [VALUE_BITS-1:0] r_div, n_div;
    logic [SQ_BITS-1:0]    r_sq, n_sq;
    logic [COUNT_BITS-1:0] r_idx, n_idx;
    logic [COUNT_BITS-1:0] r_count, n_count;
    t_verdict              r_verdict, n_verdict;

    logic                  r_out_valid, n_out_valid;
    t_verdict              r_out_verdict, n_out_verdict;
    logic [VALUE_BITS-1:0] r_out_value, n_out_value;
    logic [COUNT_BITS-1:0] r_out_count, n_out_count;

    t_mod_req              mod_req;
    t_mod_rsp              mod_rsp;
    logic                  ram_we;
    logic [ADDR_BITS-1:0]  ram_addr;
    logic [VALUE_BITS-1:0] ram_rdata;
    logic                  in_fire;

    assign in_fire = i_in.valid && i_in.ready;

    dpc_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    dpc_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (LIST_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_value),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value       <= n_value;
        r_div         <= n_div;
        r_sq          <= n_sq;
        r_idx         <= n_idx;
        r_verdict     <= n_verdict;
        r_out_verdict <= n_out_verdict;
        r_out_value   <= n_out_value;
        r_out_count   <= n_out_count;
    end

    always_comb begin
        n_state          = r_state;
        n_value          = r_value;
        n_div            = r_div;
        n_sq             = r_sq;
        n_idx            = r_idx;
        n_count          = r_count;
        n_verdict        = r_verdict;
        n_out_valid      = r_out_valid;
        n_out_verdict    = r_out_verdict;
        n_out_value      = r_out_value;
        n_out_count      = r_out_count;
        mod_req.start    = 1'b0;
        mod_req.dividend = r_value;
        mod_req.divisor  = r_div;
        ram_we           = 1'b0;
        ram_addr         = r_idx[ADDR_BITS-1:0];

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in.value[VALUE_BITS]) begin
                        n_count   = '0;
                        n_value   = '0;
                        n_verdict = V_END;
                        n_state   = S_DONE;
                    end else begin
                        n_value = i_in.value[VALUE_BITS-1:0];
                        if (i_in.value[VALUE_BITS-1:0] < FIRST_DIVISOR) begin
                            n_verdict = V_NOT_PRIME;
                            n_state   = S_DONE;
                        end else begin
                            n_div   = FIRST_DIVISOR;
                            n_sq    = FIRST_SQUARE;
                            n_state = S_CHECK;
                        end
                    end
                end
            end
            S_CHECK: begin
                if (r_sq > {1'b0, r_value}) begin
                    n_idx   = '0;
                    n_state = S_SEARCH;
                end else begin
                    mod_req.start = 1'b1;
                    n_state       = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT: begin
                if (mod_rsp.done) begin
                    if (mod_rsp.zero) begin
                        n_verdict = V_NOT_PRIME;
                        n_state   = S_DONE;
                    end else begin
                        // (d+1)^2 = d^2 + 2d + 1
                        n_div   = r_div + 1'b1;
                        n_sq    = r_sq + {r_div, 1'b1};
                        n_state = S_CHECK;
                    end
                end
            end
            S_SEARCH: begin
                if (r_idx == r_count) begin
                    if (r_count >= COUNT_BITS'(LIST_DEPTH)) begin
                        n_verdict = V_FULL;
                    end else begin
                        ram_we    = 1'b1;
                        ram_addr  = r_count[ADDR_BITS-1:0];
                        n_count   = r_count + 1'b1;
                        n_verdict = V_NEW;
                    end
                    n_state = S_DONE;
                end else begin
                    n_state = S_SEARCH_CMP;
                end
            end
            S_SEARCH_CMP: begin
                if (ram_rdata == r_value) begin
                    n_verdict = V_KNOWN;
                    n_state   = S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SEARCH;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_verdict = r_verdict;
                    n_out_value   = r_value;
                    n_out_count   = r_count;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.verdict     = r_out_verdict;
    assign o_out.echo_value  = r_out_value;
    assign o_out.prime_count = r_out_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_BITS'(LIST_DEPTH))
        else $error("prime count beyond list depth");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in.value[VALUE_BITS] |=> r_count == '0)
        else $error("end of sequence did not empty the list");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> r_count < COUNT_BITS'(LIST_DEPTH))
        else $error("store written while full");

    a_new_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_verdict == V_NEW || r_out_verdict == V_KNOWN)
            |-> r_out_count != '0)
        else $error("stored prime reported with empty list");

    a_divisor_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHECK |-> r_div >= FIRST_DIVISOR)
        else $error("trial divisor below two");

endmodule
